@@ rtl/ppp_control_protocol_automaton_macros.svh @@
// ----------------------------------------------------------------------------
// ppp_control_protocol_automaton_macros
// Assertion macros for the PPP control automaton.
// ----------------------------------------------------------------------------
`ifndef PPP_CONTROL_PROTOCOL_AUTOMATON_MACROS_SVH
`define PPP_CONTROL_PROTOCOL_AUTOMATON_MACROS_SVH
`ifndef ASSERT_OFF
`define PPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/pppca_pkg.sv @@
// ----------------------------------------------------------------------------
// pppca_pkg
// Shared types and codes of the PPP automaton, including its step result type.
// ----------------------------------------------------------------------------
`default_nettype none
package pppca_pkg;

    localparam logic [3:0] S_INITIAL  = 4'd0;
    localparam logic [3:0] S_STARTING = 4'd1;
    localparam logic [3:0] S_CLOSED   = 4'd2;
    localparam logic [3:0] S_STOPPED  = 4'd3;
    localparam logic [3:0] S_CLOSING  = 4'd4;
    localparam logic [3:0] S_STOPPING = 4'd5;
    localparam logic [3:0] S_REQSENT  = 4'd6;
    localparam logic [3:0] S_ACKRCVD  = 4'd7;
    localparam logic [3:0] S_ACKSENT  = 4'd8;
    localparam logic [3:0] S_OPENED   = 4'd9;

    localparam logic [2:0] P_NONE    = 3'd0;
    localparam logic [2:0] P_CONFREQ = 3'd1;
    localparam logic [2:0] P_CONFACK = 3'd2;
    localparam logic [2:0] P_CONFNAK = 3'd3;
    localparam logic [2:0] P_CONFREJ = 3'd4;
    localparam logic [2:0] P_TERMREQ = 3'd5;
    localparam logic [2:0] P_TERMACK = 3'd6;
    localparam logic [2:0] P_CODEREJ = 3'd7;

    localparam logic [2:0] PL_NONE    = 3'd0;
    localparam logic [2:0] PL_CHECKED = 3'd1;
    localparam logic [2:0] PL_TERM    = 3'd2;
    localparam logic [2:0] PL_OWN     = 3'd3;
    localparam logic [2:0] PL_WHOLE   = 3'd4;

    localparam logic [2:0] N_NONE       = 3'd0;
    localparam logic [2:0] N_UP         = 3'd1;
    localparam logic [2:0] N_DOWN       = 3'd2;
    localparam logic [2:0] N_STARTING   = 3'd3;
    localparam logic [2:0] N_FINISHED   = 3'd4;
    localparam logic [2:0] N_RETRANSMIT = 3'd5;

    localparam logic [1:0] T_NONE   = 2'd0;
    localparam logic [1:0] T_START  = 2'd1;
    localparam logic [1:0] T_CANCEL = 2'd2;

    // checker verdicts: request side and answer side
    localparam logic [1:0] V_ACK  = 2'd0;
    localparam logic [1:0] V_NAK  = 2'd1;
    localparam logic [1:0] V_BAD  = 2'd0;
    localparam logic [1:0] V_STOP = 2'd2;

    localparam logic [2:0] C_UP      = 3'd0;
    localparam logic [2:0] C_DOWN    = 3'd1;
    localparam logic [2:0] C_OPEN    = 3'd2;
    localparam logic [2:0] C_CLOSE   = 3'd3;
    localparam logic [2:0] C_TIMEOUT = 3'd4;
    localparam logic [2:0] C_PACKET  = 3'd5;
    localparam logic [2:0] C_PROTREJ = 3'd6;

    localparam logic [2:0] R_SILENT  = 3'd0;
    localparam logic [2:0] R_PASSIVE = 3'd1;
    localparam logic [2:0] R_RESTART = 3'd2;
    localparam logic [2:0] R_MAXCONF = 3'd3;
    localparam logic [2:0] R_MAXTERM = 3'd4;
    localparam logic [2:0] R_MAXNAK  = 3'd5;

    typedef struct packed {
        logic [3:0] link_state;
        logic [7:0] last_id;
        logic [7:0] request_id;
        logic [7:0] retry_count;
        logic [7:0] nak_count;
        logic       answer_seen;
    } ctx_t;

    typedef struct packed {
        logic       silent_mode;
        logic       passive_mode;
        logic       restart_on_open;
        logic [7:0] max_conf;
        logic [7:0] max_term;
        logic [7:0] max_nak;
    } cfg_t;

    typedef struct packed {
        logic       send;
        logic [2:0] code;
        logic [7:0] id;
        logic [2:0] payload;
        logic [2:0] notify;
        logic [1:0] timer;
        logic       reset_opt;
        logic [3:0] state_now;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  rx_code;
        logic [7:0]  rx_id;
        logic [15:0] rx_len;
        logic [15:0] rx_avail;
        logic [1:0]  verdict;
        logic        ext_handled;
    } evt_t;

    typedef struct packed {
        ctx_t ctx;
        res_t r0;
        res_t r1;
        logic two;
    } step_t;

endpackage
`default_nettype wire

@@ rtl/pppca_step.sv @@
// ----------------------------------------------------------------------------
// pppca_step
// Combinational next-state and result logic for one event.
// ----------------------------------------------------------------------------
`default_nettype none
module pppca_step (
    input  var pppca_pkg::evt_t  evt,
    input  var pppca_pkg::ctx_t  ctx,
    input  var pppca_pkg::cfg_t  cfg,
    output pppca_pkg::step_t     step
);

    pppca_pkg::ctx_t c;
    pppca_pkg::res_t r;
    pppca_pkg::res_t r0;
    logic two;
    logic [7:0] rcode;
    logic pkt_ok;

    // Conf-Req transmission; retx keeps the current identifier
    function automatic void confreq(inout pppca_pkg::ctx_t x, inout pppca_pkg::res_t y,
                                    input logic retx, input pppca_pkg::cfg_t g);
        if (x.link_state != pppca_pkg::S_REQSENT && x.link_state != pppca_pkg::S_ACKRCVD
            && x.link_state != pppca_pkg::S_ACKSENT) begin
            y.reset_opt = 1'b1;
            x.nak_count = 8'd0;
        end
        if (!retx) begin
            x.retry_count = g.max_conf;
            x.last_id = x.last_id + 8'd1;
            x.request_id = x.last_id;
        end
        x.answer_seen = 1'b0;
        y.send = 1'b1;
        y.code = pppca_pkg::P_CONFREQ;
        y.id = x.request_id;
        y.payload = pppca_pkg::PL_OWN;
        if (x.retry_count != 8'd0) x.retry_count = x.retry_count - 8'd1;
        y.timer = pppca_pkg::T_START;
    endfunction

    function automatic void termreq(inout pppca_pkg::ctx_t x, inout pppca_pkg::res_t y);
        x.last_id = x.last_id + 8'd1;
        x.request_id = x.last_id;
        y.send = 1'b1;
        y.code = pppca_pkg::P_TERMREQ;
        y.id = x.request_id;
        y.payload = pppca_pkg::PL_TERM;
        y.timer = pppca_pkg::T_START;
        if (x.retry_count != 8'd0) x.retry_count = x.retry_count - 8'd1;
    endfunction

    function automatic void pkt(inout pppca_pkg::res_t y, input logic [2:0] cd,
                                input logic [7:0] id, input logic [2:0] pl);
        y.send = 1'b1;
        y.code = cd;
        y.id = id;
        y.payload = pl;
    endfunction

    function automatic void lower_down(inout pppca_pkg::ctx_t x, inout pppca_pkg::res_t y);
        case (x.link_state)
            pppca_pkg::S_CLOSED: x.link_state = pppca_pkg::S_INITIAL;
            pppca_pkg::S_STOPPED:
            begin
                x.link_state = pppca_pkg::S_STARTING;
                y.notify = pppca_pkg::N_STARTING;
            end
            pppca_pkg::S_CLOSING:
            begin
                x.link_state = pppca_pkg::S_INITIAL;
                y.timer = pppca_pkg::T_CANCEL;
            end
            pppca_pkg::S_STOPPING, pppca_pkg::S_REQSENT, pppca_pkg::S_ACKRCVD,
            pppca_pkg::S_ACKSENT:
            begin
                x.link_state = pppca_pkg::S_STARTING;
                y.timer = pppca_pkg::T_CANCEL;
            end
            pppca_pkg::S_OPENED:
            begin
                y.notify = pppca_pkg::N_DOWN;
                x.link_state = pppca_pkg::S_STARTING;
            end
            default: ;
        endcase
    endfunction

    function automatic void lower_up(inout pppca_pkg::ctx_t x, inout pppca_pkg::res_t y,
                                     input pppca_pkg::cfg_t g);
        if (x.link_state == pppca_pkg::S_INITIAL) begin
            x.link_state = pppca_pkg::S_CLOSED;
        end else if (x.link_state == pppca_pkg::S_STARTING) begin
            if (g.silent_mode) begin
                x.link_state = pppca_pkg::S_STOPPED;
            end else begin
                confreq(x, y, 1'b0, g);
                x.link_state = pppca_pkg::S_REQSENT;
            end
        end
    endfunction

    // first result is frozen with the state at that point
    function automatic void split(inout pppca_pkg::res_t y, inout pppca_pkg::res_t y0,
                                  inout logic t, input logic [3:0] st);
        y0 = y;
        y0.state_now = st;
        t = 1'b1;
        y = '0;
    endfunction

    assign rcode = evt.rx_code;
    assign pkt_ok = !(evt.rx_avail < 16'd4 || evt.rx_len < 16'd4 || evt.rx_len > evt.rx_avail);

    always_comb
    begin
        logic [2:0] ccode;
        c = ctx;
        r = '0;
        r0 = '0;
        two = 1'b0;
        ccode = pppca_pkg::P_NONE;
        case (evt.cmd)
            pppca_pkg::C_UP: lower_up(c, r, cfg);
            pppca_pkg::C_DOWN: lower_down(c, r);
            pppca_pkg::C_OPEN:
            begin
                case (c.link_state)
                    pppca_pkg::S_INITIAL:
                    begin
                        c.link_state = pppca_pkg::S_STARTING;
                        r.notify = pppca_pkg::N_STARTING;
                    end
                    pppca_pkg::S_CLOSED:
                    begin
                        if (cfg.silent_mode) begin
                            c.link_state = pppca_pkg::S_STOPPED;
                        end else begin
                            confreq(c, r, 1'b0, cfg);
                            c.link_state = pppca_pkg::S_REQSENT;
                        end
                    end
                    pppca_pkg::S_CLOSING, pppca_pkg::S_STOPPED, pppca_pkg::S_OPENED:
                    begin
                        if (c.link_state == pppca_pkg::S_CLOSING)
                            c.link_state = pppca_pkg::S_STOPPING;
                        if (cfg.restart_on_open) begin
                            lower_down(c, r);
                            split(r, r0, two, c.link_state);
                            lower_up(c, r, cfg);
                        end
                    end
                    default: ;
                endcase
            end
            pppca_pkg::C_CLOSE:
            begin
                case (c.link_state)
                    pppca_pkg::S_STARTING: c.link_state = pppca_pkg::S_INITIAL;
                    pppca_pkg::S_STOPPED:  c.link_state = pppca_pkg::S_CLOSED;
                    pppca_pkg::S_STOPPING: c.link_state = pppca_pkg::S_CLOSING;
                    pppca_pkg::S_REQSENT, pppca_pkg::S_ACKRCVD, pppca_pkg::S_ACKSENT,
                    pppca_pkg::S_OPENED:
                    begin
                        if (c.link_state == pppca_pkg::S_OPENED) r.notify = pppca_pkg::N_DOWN;
                        else r.timer = pppca_pkg::T_CANCEL;
                        c.retry_count = cfg.max_term;
                        termreq(c, r);
                        c.link_state = pppca_pkg::S_CLOSING;
                    end
                    default: ;
                endcase
            end
            pppca_pkg::C_TIMEOUT:
            begin
                case (c.link_state)
                    pppca_pkg::S_CLOSING, pppca_pkg::S_STOPPING:
                    begin
                        if (c.retry_count == 8'd0) begin
                            c.link_state = (c.link_state == pppca_pkg::S_CLOSING) ?
                                pppca_pkg::S_CLOSED : pppca_pkg::S_STOPPED;
                            r.notify = pppca_pkg::N_FINISHED;
                        end else begin
                            termreq(c, r);
                        end
                    end
                    pppca_pkg::S_REQSENT, pppca_pkg::S_ACKRCVD, pppca_pkg::S_ACKSENT:
                    begin
                        if (c.retry_count == 8'd0) begin
                            c.link_state = pppca_pkg::S_STOPPED;
                            if (!cfg.passive_mode) r.notify = pppca_pkg::N_FINISHED;
                        end else begin
                            r.notify = pppca_pkg::N_RETRANSMIT;
                            confreq(c, r, 1'b1, cfg);
                            if (c.link_state == pppca_pkg::S_ACKRCVD)
                                c.link_state = pppca_pkg::S_REQSENT;
                        end
                    end
                    default: ;
                endcase
            end
            pppca_pkg::C_PROTREJ:
            begin
                case (c.link_state)
                    pppca_pkg::S_CLOSING, pppca_pkg::S_CLOSED:
                    begin
                        if (c.link_state == pppca_pkg::S_CLOSING) r.timer = pppca_pkg::T_CANCEL;
                        c.link_state = pppca_pkg::S_CLOSED;
                        r.notify = pppca_pkg::N_FINISHED;
                    end
                    pppca_pkg::S_STOPPING, pppca_pkg::S_REQSENT, pppca_pkg::S_ACKRCVD,
                    pppca_pkg::S_ACKSENT, pppca_pkg::S_STOPPED:
                    begin
                        if (c.link_state != pppca_pkg::S_STOPPED) r.timer = pppca_pkg::T_CANCEL;
                        c.link_state = pppca_pkg::S_STOPPED;
                        r.notify = pppca_pkg::N_FINISHED;
                    end
                    pppca_pkg::S_OPENED:
                    begin
                        r.notify = pppca_pkg::N_DOWN;
                        c.retry_count = cfg.max_term;
                        termreq(c, r);
                        c.link_state = pppca_pkg::S_STOPPING;
                    end
                    default: ;
                endcase
            end
            pppca_pkg::C_PACKET:
            begin
                if (pkt_ok && c.link_state != pppca_pkg::S_INITIAL &&
                    c.link_state != pppca_pkg::S_STARTING) begin
                    if (rcode == 8'(pppca_pkg::P_CONFREQ)) begin
                        if (c.link_state == pppca_pkg::S_CLOSED) begin
                            pkt(r, pppca_pkg::P_TERMACK, evt.rx_id, pppca_pkg::PL_NONE);
                        end else if (c.link_state != pppca_pkg::S_CLOSING &&
                                     c.link_state != pppca_pkg::S_STOPPING) begin
                            if (c.link_state == pppca_pkg::S_OPENED) begin
                                r.notify = pppca_pkg::N_DOWN;
                                confreq(c, r, 1'b0, cfg);
                                split(r, r0, two, c.link_state);
                            end else if (c.link_state == pppca_pkg::S_STOPPED) begin
                                confreq(c, r, 1'b0, cfg);
                                c.link_state = pppca_pkg::S_REQSENT;
                                split(r, r0, two, c.link_state);
                            end
                            if (evt.verdict == pppca_pkg::V_ACK) ccode = pppca_pkg::P_CONFACK;
                            else if (evt.verdict == pppca_pkg::V_NAK &&
                                     c.nak_count < cfg.max_nak)
                                ccode = pppca_pkg::P_CONFNAK;
                            else ccode = pppca_pkg::P_CONFREJ;
                            pkt(r, ccode, evt.rx_id, pppca_pkg::PL_CHECKED);
                            if (ccode == pppca_pkg::P_CONFACK) begin
                                if (c.link_state == pppca_pkg::S_ACKRCVD) begin
                                    r.timer = pppca_pkg::T_CANCEL;
                                    c.link_state = pppca_pkg::S_OPENED;
                                    r.notify = pppca_pkg::N_UP;
                                end else begin
                                    c.link_state = pppca_pkg::S_ACKSENT;
                                end
                                c.nak_count = 8'd0;
                            end else begin
                                if (c.link_state != pppca_pkg::S_ACKRCVD)
                                    c.link_state = pppca_pkg::S_REQSENT;
                                if (ccode == pppca_pkg::P_CONFNAK && c.nak_count != 8'hFF)
                                    c.nak_count = c.nak_count + 8'd1;
                            end
                        end
                    end else if (rcode == 8'(pppca_pkg::P_CONFACK) ||
                                 rcode == 8'(pppca_pkg::P_CONFNAK) ||
                                 rcode == 8'(pppca_pkg::P_CONFREJ)) begin
                        if (evt.rx_id == c.request_id && !c.answer_seen &&
                            evt.verdict != pppca_pkg::V_BAD) begin
                            c.answer_seen = 1'b1;
                            case (c.link_state)
                                pppca_pkg::S_CLOSED, pppca_pkg::S_STOPPED:
                                    pkt(r, pppca_pkg::P_TERMACK, evt.rx_id, pppca_pkg::PL_NONE);
                                pppca_pkg::S_REQSENT:
                                begin
                                    if (rcode == 8'(pppca_pkg::P_CONFACK)) begin
                                        c.link_state = pppca_pkg::S_ACKRCVD;
                                        c.retry_count = cfg.max_conf;
                                    end else if (evt.verdict == pppca_pkg::V_STOP) begin
                                        r.timer = pppca_pkg::T_CANCEL;
                                        c.link_state = pppca_pkg::S_STOPPED;
                                    end else begin
                                        confreq(c, r, 1'b0, cfg);
                                    end
                                end
                                pppca_pkg::S_ACKSENT:
                                begin
                                    if (rcode == 8'(pppca_pkg::P_CONFACK)) begin
                                        r.timer = pppca_pkg::T_CANCEL;
                                        c.link_state = pppca_pkg::S_OPENED;
                                        c.retry_count = cfg.max_conf;
                                        r.notify = pppca_pkg::N_UP;
                                    end else if (evt.verdict == pppca_pkg::V_STOP) begin
                                        r.timer = pppca_pkg::T_CANCEL;
                                        c.link_state = pppca_pkg::S_STOPPED;
                                    end else begin
                                        confreq(c, r, 1'b0, cfg);
                                    end
                                end
                                pppca_pkg::S_ACKRCVD:
                                begin
                                    confreq(c, r, 1'b0, cfg);
                                    c.link_state = pppca_pkg::S_REQSENT;
                                end
                                pppca_pkg::S_OPENED:
                                begin
                                    r.notify = pppca_pkg::N_DOWN;
                                    confreq(c, r, 1'b0, cfg);
                                    c.link_state = pppca_pkg::S_REQSENT;
                                end
                                default: ;
                            endcase
                        end
                    end else if (rcode == 8'(pppca_pkg::P_TERMREQ)) begin
                        if (c.link_state == pppca_pkg::S_ACKRCVD ||
                            c.link_state == pppca_pkg::S_ACKSENT) begin
                            c.link_state = pppca_pkg::S_REQSENT;
                        end else if (c.link_state == pppca_pkg::S_OPENED) begin
                            r.notify = pppca_pkg::N_DOWN;
                            c.retry_count = 8'd0;
                            c.link_state = pppca_pkg::S_STOPPING;
                            r.timer = pppca_pkg::T_START;
                        end
                        pkt(r, pppca_pkg::P_TERMACK, evt.rx_id, pppca_pkg::PL_NONE);
                    end else if (rcode == 8'(pppca_pkg::P_TERMACK)) begin
                        case (c.link_state)
                            pppca_pkg::S_CLOSING:
                            begin
                                r.timer = pppca_pkg::T_CANCEL;
                                c.link_state = pppca_pkg::S_CLOSED;
                                r.notify = pppca_pkg::N_FINISHED;
                            end
                            pppca_pkg::S_STOPPING:
                            begin
                                r.timer = pppca_pkg::T_CANCEL;
                                c.link_state = pppca_pkg::S_STOPPED;
                                r.notify = pppca_pkg::N_FINISHED;
                            end
                            pppca_pkg::S_ACKRCVD: c.link_state = pppca_pkg::S_REQSENT;
                            pppca_pkg::S_OPENED:
                            begin
                                r.notify = pppca_pkg::N_DOWN;
                                confreq(c, r, 1'b0, cfg);
                                c.link_state = pppca_pkg::S_REQSENT;
                            end
                            default: ;
                        endcase
                    end else if (rcode == 8'(pppca_pkg::P_CODEREJ)) begin
                        if (evt.rx_len >= 16'd8 && c.link_state == pppca_pkg::S_ACKRCVD)
                            c.link_state = pppca_pkg::S_REQSENT;
                    end else if (!evt.ext_handled) begin
                        c.last_id = c.last_id + 8'd1;
                        pkt(r, pppca_pkg::P_CODEREJ, c.last_id, pppca_pkg::PL_WHOLE);
                    end
                end
            end
            default: ;
        endcase
        r.state_now = c.link_state;
        r.last = 1'b1;
    end

    assign step.ctx = c;
    assign step.r0 = r0;
    assign step.r1 = r;
    assign step.two = two;

endmodule
`default_nettype wire

@@ rtl/ppp_control_protocol_automaton.sv @@
// An event's first result is registered and offered in the cycle after acceptance.
// One event per cycle while out_stall stays low and each event yields one result;
// a two-result event holds off new events until the single output register has drained it.
// Reset (rst_n low, asynchronous) returns to Initial with ids and counts zero
// and the configuration and valid registers at their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// ppp_control_protocol_automaton
// RFC 1661 option negotiation automaton with a result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ppp_control_protocol_automaton_macros.svh"
module ppp_control_protocol_automaton (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [7:0]  cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [2:0]  cmd,
    input  wire  [7:0]  rx_code,
    input  wire  [7:0]  rx_id,
    input  wire  [15:0] rx_len,
    input  wire  [15:0] rx_avail,
    input  wire  [1:0]  verdict,
    input  wire         ext_handled,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        send,
    output logic [2:0]  send_code,
    output logic [7:0]  send_id,
    output logic [2:0]  payload,
    output logic [2:0]  notify,
    output logic [1:0]  timer_action,
    output logic        reset_options,
    output logic [3:0]  state_now,
    output logic        last
);

    pppca_pkg::cfg_t  cfg_reg;
    pppca_pkg::ctx_t  ctx_reg;
    pppca_pkg::res_t  out_reg;
    pppca_pkg::res_t  pend_reg;   // second result of a two-result event
    logic             out_valid_reg;
    logic             pend_valid_reg;
    pppca_pkg::evt_t  evt;
    pppca_pkg::step_t step;
    logic             take_in;
    logic             take_out;

    function automatic pppca_pkg::res_t clean(input pppca_pkg::res_t x);
        pppca_pkg::res_t y;
        y = x;
        if (!x.send) begin
            y.code = 3'd0;
            y.id = 8'd0;
            y.payload = 3'd0;
        end
        return y;
    endfunction

    assign evt = '{cmd: cmd, rx_code: rx_code, rx_id: rx_id, rx_len: rx_len,
                   rx_avail: rx_avail, verdict: verdict, ext_handled: ext_handled};

    pppca_step u_step (
        .evt  (evt),
        .ctx  (ctx_reg),
        .cfg  (cfg_reg),
        .step (step)
    );

    // Output slot frees when drained; a pending second result blocks new events.
    assign take_out = out_valid_reg && !out_stall;
    assign in_stall = pend_valid_reg || (out_valid_reg && out_stall);
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{silent_mode: 1'b0, passive_mode: 1'b0, restart_on_open: 1'b0,
                         max_conf: 8'd10, max_term: 8'd2, max_nak: 8'd5};
        end else if (cfg_we) begin
            case (cfg_index)
                pppca_pkg::R_SILENT:  cfg_reg.silent_mode <= cfg_data[0];
                pppca_pkg::R_PASSIVE: cfg_reg.passive_mode <= cfg_data[0];
                pppca_pkg::R_RESTART: cfg_reg.restart_on_open <= cfg_data[0];
                pppca_pkg::R_MAXCONF: cfg_reg.max_conf <= cfg_data;
                pppca_pkg::R_MAXTERM: cfg_reg.max_term <= cfg_data;
                pppca_pkg::R_MAXNAK:  cfg_reg.max_nak <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctx_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (take_in) begin
                ctx_reg <= step.ctx;
                out_valid_reg <= 1'b1;
                pend_valid_reg <= step.two;
            end else if (take_out) begin
                out_valid_reg <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in) begin
            out_reg <= clean(step.two ? step.r0 : step.r1);
            pend_reg <= clean(step.r1);
        end else if (take_out && pend_valid_reg) begin
            out_reg <= pend_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send          = out_reg.send;
    assign send_code     = out_reg.code;
    assign send_id       = out_reg.id;
    assign payload       = out_reg.payload;
    assign notify        = out_reg.notify;
    assign timer_action  = out_reg.timer;
    assign reset_options = out_reg.reset_opt;
    assign state_now     = out_reg.state_now;
    assign last          = out_reg.last;

    `PPP_ASSERT_IMP(a_pend_needs_out, clk, rst_n, pend_valid_reg, out_valid_reg)
    `PPP_ASSERT_IMP(a_pend_first_not_last, clk, rst_n, pend_valid_reg && out_valid_reg, !last)
    `PPP_ASSERT_IMP(a_state_range, clk, rst_n, 1'b1, ctx_reg.link_state <= pppca_pkg::S_OPENED)
    `PPP_ASSERT_NEXT(a_two_then_pend, clk, rst_n, take_in && step.two, pend_valid_reg)

endmodule
`default_nettype wire

@@ tb/sv/ppp_control_protocol_automaton_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_control_protocol_automaton_test
// Self-checking bench: drives link events with random idling and stalling,
// predicts every result transaction and compares it field by field.
// ----------------------------------------------------------------------------
module ppp_control_protocol_automaton_test;
    import pppca_pkg::*;

    localparam int N_RANDOM    = 1530;
    localparam int CYCLE_LIMIT = 600000;

    // Expected-result tracker with its own copy of the automaton.
    class link_scoreboard;
        res_t       pending_q[$];
        int         errors;
        logic       silent, passive, restart;
        logic [7:0] max_conf, max_term, max_nak;
        logic [3:0] st;
        logic [7:0] last_id, request_id, retry, naks;
        bit         answered;
        // result under construction
        logic       c_send;
        logic [2:0] c_code, c_pl, c_notify;
        logic [7:0] c_id;
        logic [1:0] c_timer;
        logic       c_reset;
        int         nres;

        function new();
            errors = 0; silent = 1'b0; passive = 1'b0; restart = 1'b0;
            max_conf = 8'd10; max_term = 8'd2; max_nak = 8'd5;
            st = S_INITIAL; last_id = 8'd0; request_id = 8'd0; retry = 8'd0; naks = 8'd0;
            answered = 1'b0;
            nres = 0;
            clear_cur();
        endfunction

        function void configure(logic [2:0] idx, logic [7:0] val);
            case (idx)
                R_SILENT:  silent = val[0];
                R_PASSIVE: passive = val[0];
                R_RESTART: restart = val[0];
                R_MAXCONF: max_conf = val;
                R_MAXTERM: max_term = val;
                R_MAXNAK:  max_nak = val;
                default: ;
            endcase
        endfunction

        function void clear_cur();
            c_send = 1'b0; c_code = P_NONE; c_id = 8'd0; c_pl = PL_NONE;
            c_notify = N_NONE; c_timer = T_NONE; c_reset = 1'b0;
        endfunction

        function void flush(bit is_last);
            res_t r;
            if (nres >= 2) return;
            r.send = c_send;
            r.code = c_send ? c_code : P_NONE;
            r.id = c_send ? c_id : 8'd0;
            r.payload = c_send ? c_pl : PL_NONE;
            r.notify = c_notify;
            r.timer = c_timer;
            r.reset_opt = c_reset;
            r.state_now = st;
            r.last = is_last;
            pending_q.push_back(r);
            nres++;
            clear_cur();
        endfunction

        function void tx(logic [2:0] code, logic [7:0] id, logic [2:0] pl);
            c_send = 1'b1; c_code = code; c_id = id; c_pl = pl;
        endfunction

        function void dec_retry();
            if (retry != 8'd0) retry--;
        endfunction

        function void conf_req(bit retx);
            if (st != S_REQSENT && st != S_ACKRCVD && st != S_ACKSENT) begin
                c_reset = 1'b1;
                naks = 8'd0;
            end
            if (!retx) begin
                retry = max_conf;
                last_id++;
                request_id = last_id;
            end
            answered = 1'b0;
            tx(P_CONFREQ, request_id, PL_OWN);
            dec_retry();
            c_timer = T_START;
        endfunction

        function void term_req();
            last_id++;
            request_id = last_id;
            tx(P_TERMREQ, request_id, PL_TERM);
            c_timer = T_START;
            dec_retry();
        endfunction

        function void go_up();
            if (st == S_INITIAL) st = S_CLOSED;
            else if (st == S_STARTING) begin
                if (silent) st = S_STOPPED;
                else begin
                    conf_req(1'b0);
                    st = S_REQSENT;
                end
            end
        endfunction

        function void go_down();
            case (st)
                S_CLOSED:  st = S_INITIAL;
                S_STOPPED: begin st = S_STARTING; c_notify = N_STARTING; end
                S_CLOSING: begin st = S_INITIAL; c_timer = T_CANCEL; end
                S_STOPPING, S_REQSENT, S_ACKRCVD, S_ACKSENT:
                begin
                    st = S_STARTING; c_timer = T_CANCEL;
                end
                S_OPENED:  begin c_notify = N_DOWN; st = S_STARTING; end
                default: ;
            endcase
        endfunction

        function void open_link();
            case (st)
                S_INITIAL: begin st = S_STARTING; c_notify = N_STARTING; end
                S_CLOSED:
                    if (silent) st = S_STOPPED;
                    else begin
                        conf_req(1'b0);
                        st = S_REQSENT;
                    end
                S_CLOSING, S_STOPPED, S_OPENED:
                begin
                    if (st == S_CLOSING) st = S_STOPPING;
                    // restart: down step as first result, up step as second
                    if (restart) begin
                        go_down();
                        flush(1'b0);
                        go_up();
                    end
                end
                default: ;
            endcase
        endfunction

        function void close_link();
            case (st)
                S_STARTING: st = S_INITIAL;
                S_STOPPED:  st = S_CLOSED;
                S_STOPPING: st = S_CLOSING;
                S_REQSENT, S_ACKRCVD, S_ACKSENT, S_OPENED:
                begin
                    if (st == S_OPENED) c_notify = N_DOWN;
                    else c_timer = T_CANCEL;
                    retry = max_term;
                    term_req();
                    st = S_CLOSING;
                end
                default: ;
            endcase
        endfunction

        function void timer_expired();
            case (st)
                S_CLOSING, S_STOPPING:
                    if (retry == 8'd0) begin
                        st = (st == S_CLOSING) ? S_CLOSED : S_STOPPED;
                        c_notify = N_FINISHED;
                    end
                    else term_req();
                S_REQSENT, S_ACKRCVD, S_ACKSENT:
                    if (retry == 8'd0) begin
                        st = S_STOPPED;
                        if (!passive) c_notify = N_FINISHED;
                    end
                    else begin
                        c_notify = N_RETRANSMIT;
                        conf_req(1'b1);
                        if (st == S_ACKRCVD) st = S_REQSENT;
                    end
                default: ;
            endcase
        endfunction

        function void prot_reject();
            case (st)
                S_CLOSING, S_CLOSED:
                begin
                    if (st == S_CLOSING) c_timer = T_CANCEL;
                    st = S_CLOSED;
                    c_notify = N_FINISHED;
                end
                S_STOPPING, S_REQSENT, S_ACKRCVD, S_ACKSENT, S_STOPPED:
                begin
                    if (st != S_STOPPED) c_timer = T_CANCEL;
                    st = S_STOPPED;
                    c_notify = N_FINISHED;
                end
                S_OPENED:
                begin
                    c_notify = N_DOWN;
                    retry = max_term;
                    term_req();
                    st = S_STOPPING;
                end
                default: ;
            endcase
        endfunction

        function void rx_conf_req(logic [7:0] id, logic [1:0] vd);
            logic [2:0] code;
            case (st)
                S_CLOSED: begin tx(P_TERMACK, id, PL_NONE); return; end
                S_CLOSING, S_STOPPING: return;
                S_OPENED:
                begin
                    c_notify = N_DOWN;
                    conf_req(1'b0);
                    flush(1'b0);
                end
                S_STOPPED:
                begin
                    conf_req(1'b0);
                    st = S_REQSENT;
                    flush(1'b0);
                end
                default: ;
            endcase
            // nak loop limit turns a nak into a reject
            if (vd == V_ACK) code = P_CONFACK;
            else if (vd == V_NAK && naks < max_nak) code = P_CONFNAK;
            else code = P_CONFREJ;
            tx(code, id, PL_CHECKED);
            if (code == P_CONFACK) begin
                if (st == S_ACKRCVD) begin
                    c_timer = T_CANCEL;
                    st = S_OPENED;
                    c_notify = N_UP;
                end
                else st = S_ACKSENT;
                naks = 8'd0;
            end
            else begin
                if (st != S_ACKRCVD) st = S_REQSENT;
                if (code == P_CONFNAK && naks != 8'hFF) naks++;
            end
        endfunction

        function void rx_conf_ack(logic [7:0] id, logic [1:0] vd);
            if (id != request_id || answered || vd == V_BAD) return;
            answered = 1'b1;
            case (st)
                S_CLOSED, S_STOPPED: tx(P_TERMACK, id, PL_NONE);
                S_REQSENT: begin st = S_ACKRCVD; retry = max_conf; end
                S_ACKRCVD: begin conf_req(1'b0); st = S_REQSENT; end
                S_ACKSENT:
                begin
                    c_timer = T_CANCEL;
                    st = S_OPENED;
                    retry = max_conf;
                    c_notify = N_UP;
                end
                S_OPENED: begin c_notify = N_DOWN; conf_req(1'b0); st = S_REQSENT; end
                default: ;
            endcase
        endfunction

        function void rx_nak_rej(logic [7:0] id, logic [1:0] vd);
            if (id != request_id || answered || vd == V_BAD) return;
            answered = 1'b1;
            case (st)
                S_CLOSED, S_STOPPED: tx(P_TERMACK, id, PL_NONE);
                S_REQSENT, S_ACKSENT:
                    if (vd == V_STOP) begin
                        c_timer = T_CANCEL;
                        st = S_STOPPED;
                    end
                    else conf_req(1'b0);
                S_ACKRCVD: begin conf_req(1'b0); st = S_REQSENT; end
                S_OPENED: begin c_notify = N_DOWN; conf_req(1'b0); st = S_REQSENT; end
                default: ;
            endcase
        endfunction

        function void rx_term_req(logic [7:0] id);
            if (st == S_ACKRCVD || st == S_ACKSENT) st = S_REQSENT;
            else if (st == S_OPENED) begin
                c_notify = N_DOWN;
                retry = 8'd0;
                st = S_STOPPING;
                c_timer = T_START;
            end
            tx(P_TERMACK, id, PL_NONE);
        endfunction

        function void rx_term_ack();
            case (st)
                S_CLOSING:
                begin
                    c_timer = T_CANCEL; st = S_CLOSED; c_notify = N_FINISHED;
                end
                S_STOPPING:
                begin
                    c_timer = T_CANCEL; st = S_STOPPED; c_notify = N_FINISHED;
                end
                S_ACKRCVD: st = S_REQSENT;
                S_OPENED: begin c_notify = N_DOWN; conf_req(1'b0); st = S_REQSENT; end
                default: ;
            endcase
        endfunction

        function void rx_packet(evt_t e);
            if (e.rx_avail < 16'd4 || e.rx_len < 16'd4 || e.rx_len > e.rx_avail) return;
            if (st == S_INITIAL || st == S_STARTING) return;
            case (e.rx_code)
                8'(P_CONFREQ): rx_conf_req(e.rx_id, e.verdict);
                8'(P_CONFACK): rx_conf_ack(e.rx_id, e.verdict);
                8'(P_CONFNAK), 8'(P_CONFREJ): rx_nak_rej(e.rx_id, e.verdict);
                8'(P_TERMREQ): rx_term_req(e.rx_id);
                8'(P_TERMACK): rx_term_ack();
                8'(P_CODEREJ): if (e.rx_len >= 16'd8 && st == S_ACKRCVD) st = S_REQSENT;
                default:
                    if (!e.ext_handled) begin
                        last_id++;
                        tx(P_CODEREJ, last_id, PL_WHOLE);
                    end
            endcase
        endfunction

        // Accepted event: queue the results it causes.
        function void note_event(evt_t e);
            nres = 0;
            clear_cur();
            case (e.cmd)
                C_UP:      go_up();
                C_DOWN:    go_down();
                C_OPEN:    open_link();
                C_CLOSE:   close_link();
                C_TIMEOUT: timer_expired();
                C_PACKET:  rx_packet(e);
                C_PROTREJ: prot_reject();
                default: ;
            endcase
            flush(1'b1);
        endfunction

        task report(string what, int got, int want);
            $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
            errors++;
        endtask

        task field(string name, int got, int want);
            if (got != want) report(name, got, want);
        endtask

        task check_result(res_t r);
            res_t w;
            if (pending_q.size() == 0) begin
                report("result with nothing pending", int'(r.state_now), 0);
                return;
            end
            w = pending_q.pop_front();
            field("send", int'(r.send), int'(w.send));
            field("send_code", int'(r.code), int'(w.code));
            field("send_id", int'(r.id), int'(w.id));
            field("payload", int'(r.payload), int'(w.payload));
            field("notify", int'(r.notify), int'(w.notify));
            field("timer_action", int'(r.timer), int'(w.timer));
            field("reset_options", int'(r.reset_opt), int'(w.reset_opt));
            field("state_now", int'(r.state_now), int'(w.state_now));
            field("last", int'(r.last), int'(w.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd = '0;
    logic [7:0]  rx_code = '0;
    logic [7:0]  rx_id = '0;
    logic [15:0] rx_len = '0;
    logic [15:0] rx_avail = '0;
    logic [1:0]  verdict = '0;
    logic        ext_handled = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        send;
    logic [2:0]  send_code;
    logic [7:0]  send_id;
    logic [2:0]  payload;
    logic [2:0]  notify;
    logic [1:0]  timer_action;
    logic        reset_options;
    logic [3:0]  state_now;
    logic        last;

    link_scoreboard sb = new();
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             cycles = 0;

    ppp_control_protocol_automaton i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .rx_code(rx_code), .rx_id(rx_id), .rx_len(rx_len),
        .rx_avail(rx_avail), .verdict(verdict), .ext_handled(ext_handled),
        .out_valid(out_valid), .out_stall(out_stall),
        .send(send), .send_code(send_code), .send_id(send_id),
        .payload(payload), .notify(notify), .timer_action(timer_action),
        .reset_options(reset_options), .state_now(state_now), .last(last)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stall, changed on the falling edge only
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor: a transaction completes on valid and no stall
    always @(posedge clk)
    begin
        res_t r;
        if (rst_n && out_valid && !out_stall) begin
            r.send = send; r.code = send_code; r.id = send_id;
            r.payload = payload; r.notify = notify; r.timer = timer_action;
            r.reset_opt = reset_options; r.state_now = state_now; r.last = last;
            sb.check_result(r);
        end
    end

    // Wait until all results are out, then let the output register drain.
    task wait_idle();
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task write_reg(logic [2:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        sb.configure(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task load_config(logic s, logic p, logic r, logic [7:0] mc, logic [7:0] mt,
                     logic [7:0] mn);
        wait_idle();
        write_reg(R_SILENT, {7'd0, s});
        write_reg(R_PASSIVE, {7'd0, p});
        write_reg(R_RESTART, {7'd0, r});
        write_reg(R_MAXCONF, mc);
        write_reg(R_MAXTERM, mt);
        write_reg(R_MAXNAK, mn);
    endtask

    // Offer one event from a falling edge; return once it has been taken.
    task drive_event(evt_t e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        {cmd, rx_code, rx_id, rx_len, rx_avail, verdict, ext_handled} = e;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        sb.note_event(e);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic evt_t pkt(logic [7:0] code, logic [7:0] id, logic [15:0] len,
                                 logic [15:0] avail, logic [1:0] vd, logic ext);
        evt_t e;
        e.cmd = C_PACKET; e.rx_code = code; e.rx_id = id; e.rx_len = len;
        e.rx_avail = avail; e.verdict = vd; e.ext_handled = ext;
        return e;
    endfunction

    function automatic evt_t ctl(logic [2:0] c);
        evt_t e;
        e = pkt(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                2'($urandom), 1'($urandom));
        e.cmd = c;
        return e;
    endfunction

    // Mostly well-formed packets that answer the current request,
    // some control events, some raw noise.
    function automatic evt_t random_event();
        evt_t e;
        int   k;
        k = $urandom_range(0, 99);
        e = ctl(3'($urandom_range(0, 6)));
        if (k < 60) begin
            e.cmd = C_PACKET;
            e.rx_code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 7));
            e.rx_avail = 16'($urandom_range(4, 64));
            e.rx_len = 16'($urandom_range(4, int'(e.rx_avail)));
            if ($urandom_range(0, 9) < 7) e.rx_id = sb.request_id;
            e.verdict = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
        end
        else if (k < 88) begin
            while (e.cmd == C_PACKET) e.cmd = 3'($urandom_range(0, 6));
        end
        return e;
    endfunction

    task random_phase(int items, int idle, int stall, bit hold_off);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < items; i++) begin
            // sender hold-off until everything pending has come out
            if (hold_off && i == items / 2)
                while (sb.pending_q.size() != 0) @(negedge clk);
            drive_event(random_event());
        end
    endtask

    initial
    begin
        #1;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed walk with reset defaults
        load_config(1'b0, 1'b0, 1'b0, 8'd10, 8'd2, 8'd5);
        drive_event(pkt(8'd1, 8'd0, 16'd4, 16'd4, 2'd0, 1'b0));      // dropped in Initial
        drive_event(ctl(C_UP));
        drive_event(ctl(C_OPEN));
        drive_event(pkt(8'd1, 8'hFF, 16'd8, 16'd8, 2'd1, 1'b0));     // nak
        drive_event(pkt(8'd1, 8'h00, 16'd8, 16'd8, 2'd3, 1'b0));     // reject
        drive_event(pkt(8'd2, sb.request_id, 16'd4, 16'd4, 2'd2, 1'b0)); // stop counts as good
        drive_event(pkt(8'd1, 8'd7, 16'hFFFF, 16'hFFFF, 2'd0, 1'b0)); // ack -> Opened
        drive_event(pkt(8'd0, 8'd1, 16'd5, 16'd5, 2'd0, 1'b0));      // unknown code
        drive_event(pkt(8'hFF, 8'd1, 16'd5, 16'd5, 2'd0, 1'b1));     // extension handled
        drive_event(pkt(8'd1, 8'd9, 16'd5, 16'd3, 2'd0, 1'b0));      // len above avail
        drive_event(pkt(8'd1, 8'd9, 16'd3, 16'd3, 2'd0, 1'b0));      // too short
        drive_event(pkt(8'd6, 8'd0, 16'd4, 16'd4, 2'd0, 1'b0));      // term-ack in Opened
        drive_event(pkt(8'd7, 8'd0, 16'd7, 16'd7, 2'd0, 1'b0));      // short code-reject
        drive_event(pkt(8'd3, sb.request_id, 16'd4, 16'd4, 2'd2, 1'b0)); // stop -> Stopped
        drive_event(pkt(8'd1, 8'd3, 16'd4, 16'd4, 2'd0, 1'b0));      // two results
        drive_event(ctl(C_TIMEOUT));
        drive_event(ctl(C_PROTREJ));
        drive_event(ctl(C_CLOSE));
        drive_event(ctl(C_TIMEOUT));
        drive_event(ctl(C_TIMEOUT));
        drive_event(ctl(C_TIMEOUT));
        drive_event(ctl(C_DOWN));
        random_phase(N_RANDOM / 4, 0, 0, 1'b0);

        load_config(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0);
        random_phase(N_RANDOM / 4, 83, 0, 1'b1);

        load_config(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        random_phase(N_RANDOM / 4, 0, 83, 1'b0);

        load_config(1'b0, 1'b1, 1'b1, 8'd3, 8'd1, 8'd2);
        drive_event(ctl(C_OPEN));
        random_phase(N_RANDOM / 4, 28, 28, 1'b0);

        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/pppca_pkg.sv
rtl/pppca_step.sv
rtl/ppp_control_protocol_automaton.sv
tb/sv/ppp_control_protocol_automaton_test.sv
